// File: rtl/pi_controller_antiwindup_core_assert.svh
// assertion macros for the pi controller core
// used by modules that check their own control sequencing
`ifndef PI_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH
`define PI_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH

// same-cycle implication
`define PIAW_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIAW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/piaw_pkg.sv
// shared types, constants, saturation helpers and microcode rom
// for the pi controller core; no dependencies
package piaw_pkg;

  localparam int DataW    = 32;
  localparam int FracBits = 16;
  localparam int GainW    = 31;
  localparam int StepW    = 5;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [GainW-1:0]        gain_t;
  typedef logic [StepW-1:0]        step_t;

  localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};
  localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_ON     = 2'd1,
    REQ_OFF    = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_KP         = 3'd0,
    CFG_KI_TS      = 3'd1,
    CFG_KB         = 3'd2,
    CFG_DEADZONE   = 3'd3,
    CFG_OUT_MIN    = 3'd4,
    CFG_OUT_MAX    = 3'd5,
    CFG_OUT_OFFSET = 3'd6,
    CFG_IN_OFFSET  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    req_e  req_type;
    data_t measurement;
    data_t setpoint;
  } req_t;

  typedef struct packed {
    data_t drive;
    logic  running;
  } res_t;

  typedef struct packed {
    cfg_idx_e          index;
    logic [DataW-1:0]  wdata;
  } cfg_t;

  typedef struct packed {
    gain_t kp;
    gain_t ki_ts;
    gain_t kb;
    gain_t deadzone;
    data_t out_min;
    data_t out_max;
    data_t out_offset;
    data_t in_offset;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_DZ,
    OP_MUL,
    OP_SHF,
    OP_CLAMP,
    OP_SETRUN,
    OP_CLRRUN
  } op_e;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_MEAS,
    SRC_SP,
    SRC_T,
    SRC_ERR,
    SRC_P,
    SRC_INT,
    SRC_COR,
    SRC_UNC,
    SRC_DRV,
    SRC_OUT_OFS,
    SRC_IN_OFS,
    SRC_KP,
    SRC_KI,
    SRC_KB
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_T,
    DST_ERR,
    DST_P,
    DST_INT,
    DST_COR,
    DST_UNC,
    DST_DRV
  } dst_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_REQ_ON,
    COND_REQ_OFF,
    COND_REQ_NOP,
    COND_STOPPED,
    COND_KI_ZERO
  } cond_e;

  typedef struct packed {
    op_e   op;
    src_e  src_a;
    src_e  src_b;
    dst_e  dst;
    cond_e cond;
    step_t target;
    logic  last;
  } ucode_t;

  typedef struct packed {
    logic  load;
    op_e   op;
    src_e  src_a;
    src_e  src_b;
    dst_e  dst;
  } ctrl_t;

  typedef struct packed {
    data_t drive;
    logic  running;
    logic  ki_zero;
  } stat_t;

  // program entry points
  localparam step_t StepOfs = StepW'(15);
  localparam step_t StepKiz = StepW'(13);
  localparam step_t StepPi  = StepW'(14);
  localparam step_t StepOn  = StepW'(20);
  localparam step_t StepOff = StepW'(21);
  localparam step_t StepEnd = StepW'(25);

  function automatic data_t sat_sum(logic signed [DataW:0] s);
    data_t r;
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? DataMin : DataMax;
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

  // product >>> frac bits, saturated
  function automatic data_t sat_prod(logic signed [2*DataW-1:0] p);
    logic signed [2*DataW-FracBits-1:0] s;
    data_t r;
    s = p[2*DataW-1:FracBits];
    if ((&s[2*DataW-FracBits-1:DataW-1]) || !(|s[2*DataW-FracBits-1:DataW-1])) begin
      r = s[DataW-1:0];
    end else begin
      r = s[2*DataW-FracBits-1] ? DataMin : DataMax;
    end
    return r;
  endfunction

  function automatic ucode_t uw(op_e op, src_e a, src_e b, dst_e d, cond_e c,
                                step_t t, logic last);
    ucode_t w;
    w.op     = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.cond   = c;
    w.target = t;
    w.last   = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    case (step)
      // dispatch
      5'd0:  w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, COND_REQ_ON, StepOn, 1'b0);
      5'd1:  w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, COND_REQ_OFF, StepOff, 1'b0);
      5'd2:  w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, COND_REQ_NOP, StepEnd, 1'b0);
      5'd3:  w = uw(OP_MOV, SRC_ZERO, SRC_ZERO, DST_UNC, COND_STOPPED, StepOfs, 1'b0);
      // error and proportional term
      5'd4:  w = uw(OP_SUB, SRC_MEAS, SRC_IN_OFS, DST_T, COND_NEVER, '0, 1'b0);
      5'd5:  w = uw(OP_SUB, SRC_SP, SRC_T, DST_ERR, COND_NEVER, '0, 1'b0);
      5'd6:  w = uw(OP_DZ, SRC_ERR, SRC_ZERO, DST_ERR, COND_NEVER, '0, 1'b0);
      5'd7:  w = uw(OP_MUL, SRC_KP, SRC_ERR, DST_NONE, COND_NEVER, '0, 1'b0);
      5'd8:  w = uw(OP_SHF, SRC_ZERO, SRC_ZERO, DST_P, COND_NEVER, '0, 1'b0);
      // integrator
      5'd9:  w = uw(OP_ADD, SRC_ERR, SRC_COR, DST_T, COND_KI_ZERO, StepKiz, 1'b0);
      5'd10: w = uw(OP_MUL, SRC_KI, SRC_T, DST_NONE, COND_NEVER, '0, 1'b0);
      5'd11: w = uw(OP_SHF, SRC_ZERO, SRC_ZERO, DST_T, COND_NEVER, '0, 1'b0);
      5'd12: w = uw(OP_ADD, SRC_INT, SRC_T, DST_INT, COND_ALWAYS, StepPi, 1'b0);
      5'd13: w = uw(OP_MOV, SRC_ZERO, SRC_ZERO, DST_INT, COND_NEVER, '0, 1'b0);
      5'd14: w = uw(OP_ADD, SRC_P, SRC_INT, DST_UNC, COND_NEVER, '0, 1'b0);
      // offset, clamp, back-calculation
      5'd15: w = uw(OP_ADD, SRC_UNC, SRC_OUT_OFS, DST_UNC, COND_NEVER, '0, 1'b0);
      5'd16: w = uw(OP_CLAMP, SRC_UNC, SRC_ZERO, DST_DRV, COND_NEVER, '0, 1'b0);
      5'd17: w = uw(OP_SUB, SRC_DRV, SRC_UNC, DST_T, COND_NEVER, '0, 1'b0);
      5'd18: w = uw(OP_MUL, SRC_KB, SRC_T, DST_NONE, COND_NEVER, '0, 1'b0);
      5'd19: w = uw(OP_SHF, SRC_ZERO, SRC_ZERO, DST_COR, COND_ALWAYS, StepEnd, 1'b0);
      // turn on
      5'd20: w = uw(OP_SETRUN, SRC_ZERO, SRC_ZERO, DST_NONE, COND_ALWAYS, StepEnd, 1'b0);
      // turn off
      5'd21: w = uw(OP_MOV, SRC_ZERO, SRC_ZERO, DST_INT, COND_NEVER, '0, 1'b0);
      5'd22: w = uw(OP_MOV, SRC_ZERO, SRC_ZERO, DST_COR, COND_NEVER, '0, 1'b0);
      5'd23: w = uw(OP_CLRRUN, SRC_ZERO, SRC_ZERO, DST_NONE, COND_NEVER, '0, 1'b0);
      5'd24: w = uw(OP_MOV, SRC_OUT_OFS, SRC_ZERO, DST_DRV, COND_NEVER, '0, 1'b0);
      default: w = uw(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, COND_NEVER, '0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/piaw_stream_if.sv
// valid/ready channel carrying one payload item
// payload type comes from piaw_pkg at the instantiating level
interface piaw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/pi_controller_antiwindup_core.sv
// PI controller with deadzone, output clamp and back-calculation anti-windup.
// Every item (sample step, turn on, turn off, unused request code) runs a short
// microcode program, one control word per cycle, through one shared 32x32
// multiplier and a saturating adder; all values are signed Q16.16. The last
// word of a program waits while an earlier result has not been taken. A sample
// step while running makes three multiply-and-scale passes and skips the
// integrator pass when ki_ts is zero; while stopped it makes only the
// back-calculation pass. The next item is taken the cycle after the result is
// formed, even while that result waits.
// Depends on piaw_pkg, piaw_stream_if, piaw_cfg_regs, piaw_datapath, piaw_sequencer.
module pi_controller_antiwindup_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  piaw_stream_if.sink   req_i,
  piaw_stream_if.source res_o,
  piaw_stream_if.sink   cfg_i
);

  piaw_pkg::cfg_regs_t regs;
  piaw_pkg::ctrl_t     ctrl;
  piaw_pkg::stat_t     stat;

  piaw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .cfg_ready_o (cfg_i.ready),
    .regs_o      (regs)
  );

  piaw_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i.payload),
    .cfg_i  (regs),
    .stat_o (stat)
  );

  piaw_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.payload.req_type),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_o       (res_o.payload),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

endmodule

// File: rtl/piaw_cfg_regs.sv
// configuration register file of the pi controller core
// depends on piaw_pkg
module piaw_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  piaw_pkg::cfg_t      cfg_i,
  output logic                cfg_ready_o,
  output piaw_pkg::cfg_regs_t regs_o
);

  piaw_pkg::cfg_regs_t regs_q;

  assign cfg_ready_o = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.kp         <= '0;
      regs_q.ki_ts      <= '0;
      regs_q.kb         <= '0;
      regs_q.deadzone   <= '0;
      regs_q.out_min    <= piaw_pkg::DataMin;
      regs_q.out_max    <= piaw_pkg::DataMax;
      regs_q.out_offset <= '0;
      regs_q.in_offset  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.index)
        piaw_pkg::CFG_KP:         regs_q.kp         <= cfg_i.wdata[piaw_pkg::GainW-1:0];
        piaw_pkg::CFG_KI_TS:      regs_q.ki_ts      <= cfg_i.wdata[piaw_pkg::GainW-1:0];
        piaw_pkg::CFG_KB:         regs_q.kb         <= cfg_i.wdata[piaw_pkg::GainW-1:0];
        piaw_pkg::CFG_DEADZONE:   regs_q.deadzone   <= cfg_i.wdata[piaw_pkg::GainW-1:0];
        piaw_pkg::CFG_OUT_MIN:    regs_q.out_min    <= cfg_i.wdata;
        piaw_pkg::CFG_OUT_MAX:    regs_q.out_max    <= cfg_i.wdata;
        piaw_pkg::CFG_OUT_OFFSET: regs_q.out_offset <= cfg_i.wdata;
        piaw_pkg::CFG_IN_OFFSET:  regs_q.in_offset  <= cfg_i.wdata;
      endcase
    end
  end

endmodule

// File: rtl/piaw_datapath.sv
// register file, saturating alu and shared multiplier driven by the control word
// depends on piaw_pkg
module piaw_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  piaw_pkg::ctrl_t     ctrl_i,
  input  piaw_pkg::req_t      req_i,
  input  piaw_pkg::cfg_regs_t cfg_i,
  output piaw_pkg::stat_t     stat_o
);

  localparam int W = piaw_pkg::DataW;

  piaw_pkg::data_t meas_q, sp_q, t_q, err_q, p_q, unc_q;
  piaw_pkg::data_t int_q, cor_q, drv_q;
  logic            run_q;
  logic signed [2*W-1:0] prod_q;

  piaw_pkg::data_t a_v, b_v, res;
  logic signed [W:0] sum, dif, e_x, dz_x, ndz_x;
  logic signed [2*W-1:0] prod;
  logic wr_en;

  function automatic piaw_pkg::data_t pick(piaw_pkg::src_e s);
    piaw_pkg::data_t v;
    unique case (s)
      piaw_pkg::SRC_ZERO:    v = '0;
      piaw_pkg::SRC_MEAS:    v = meas_q;
      piaw_pkg::SRC_SP:      v = sp_q;
      piaw_pkg::SRC_T:       v = t_q;
      piaw_pkg::SRC_ERR:     v = err_q;
      piaw_pkg::SRC_P:       v = p_q;
      piaw_pkg::SRC_INT:     v = int_q;
      piaw_pkg::SRC_COR:     v = cor_q;
      piaw_pkg::SRC_UNC:     v = unc_q;
      piaw_pkg::SRC_DRV:     v = drv_q;
      piaw_pkg::SRC_OUT_OFS: v = cfg_i.out_offset;
      piaw_pkg::SRC_IN_OFS:  v = cfg_i.in_offset;
      piaw_pkg::SRC_KP:      v = {{(W-piaw_pkg::GainW){1'b0}}, cfg_i.kp};
      piaw_pkg::SRC_KI:      v = {{(W-piaw_pkg::GainW){1'b0}}, cfg_i.ki_ts};
      piaw_pkg::SRC_KB:      v = {{(W-piaw_pkg::GainW){1'b0}}, cfg_i.kb};
      default:               v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    a_v   = pick(ctrl_i.src_a);
    b_v   = pick(ctrl_i.src_b);
    sum   = {a_v[W-1], a_v} + {b_v[W-1], b_v};
    dif   = {a_v[W-1], a_v} - {b_v[W-1], b_v};
    e_x   = {a_v[W-1], a_v};
    dz_x  = {{(W+1-piaw_pkg::GainW){1'b0}}, cfg_i.deadzone};
    ndz_x = -dz_x;
    prod  = a_v * b_v;
    res   = '0;
    wr_en = 1'b0;
    unique case (ctrl_i.op)
      piaw_pkg::OP_MOV: begin
        res   = a_v;
        wr_en = 1'b1;
      end
      piaw_pkg::OP_ADD: begin
        res   = piaw_pkg::sat_sum(sum);
        wr_en = 1'b1;
      end
      piaw_pkg::OP_SUB: begin
        res   = piaw_pkg::sat_sum(dif);
        wr_en = 1'b1;
      end
      piaw_pkg::OP_DZ: begin
        // small errors inside the dead band count as zero
        res   = ((cfg_i.deadzone != '0) && (e_x < dz_x) && (e_x > ndz_x)) ? '0 : a_v;
        wr_en = 1'b1;
      end
      piaw_pkg::OP_SHF: begin
        res   = piaw_pkg::sat_prod(prod_q);
        wr_en = 1'b1;
      end
      piaw_pkg::OP_CLAMP: begin
        if (a_v < cfg_i.out_min) begin
          res = cfg_i.out_min;
        end else if (a_v > cfg_i.out_max) begin
          res = cfg_i.out_max;
        end else begin
          res = a_v;
        end
        wr_en = 1'b1;
      end
      default: begin
        res   = '0;
        wr_en = 1'b0;
      end
    endcase
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      meas_q <= req_i.measurement;
      sp_q   <= req_i.setpoint;
    end
    if (ctrl_i.op == piaw_pkg::OP_MUL) begin
      prod_q <= prod;
    end
    if (wr_en) begin
      case (ctrl_i.dst)
        piaw_pkg::DST_T:   t_q   <= res;
        piaw_pkg::DST_ERR: err_q <= res;
        piaw_pkg::DST_P:   p_q   <= res;
        piaw_pkg::DST_UNC: unc_q <= res;
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0;
      cor_q <= '0;
      drv_q <= '0;
      run_q <= 1'b0;
    end else begin
      if (wr_en) begin
        case (ctrl_i.dst)
          piaw_pkg::DST_INT: int_q <= res;
          piaw_pkg::DST_COR: cor_q <= res;
          piaw_pkg::DST_DRV: drv_q <= res;
          default: ;
        endcase
      end
      if (ctrl_i.op == piaw_pkg::OP_SETRUN) begin
        run_q <= 1'b1;
      end else if (ctrl_i.op == piaw_pkg::OP_CLRRUN) begin
        run_q <= 1'b0;
      end
    end
  end

  assign stat_o.drive   = drv_q;
  assign stat_o.running = run_q;
  assign stat_o.ki_zero = (cfg_i.ki_ts == '0);

endmodule

// File: rtl/piaw_sequencer.sv
// microcode sequencer: step counter, conditional jumps, item handshake
// and result register; depends on piaw_pkg and the assertion macro header
`include "pi_controller_antiwindup_core_assert.svh"

module piaw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  piaw_pkg::req_e  req_type_i,
  output logic            req_ready_o,
  input  logic            res_ready_i,
  output logic            res_valid_o,
  output piaw_pkg::res_t  res_o,
  input  piaw_pkg::stat_t stat_i,
  output piaw_pkg::ctrl_t ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e           state_q;
  piaw_pkg::step_t  step_q;
  piaw_pkg::req_e   rtype_q;
  logic             res_valid_q;
  piaw_pkg::res_t   res_q;

  piaw_pkg::ucode_t uw;
  logic             accept, take, finish;

  always_comb begin
    uw = piaw_pkg::ucode_rom(step_q);
    unique case (uw.cond)
      piaw_pkg::COND_NEVER:   take = 1'b0;
      piaw_pkg::COND_ALWAYS:  take = 1'b1;
      piaw_pkg::COND_REQ_ON:  take = (rtype_q == piaw_pkg::REQ_ON);
      piaw_pkg::COND_REQ_OFF: take = (rtype_q == piaw_pkg::REQ_OFF);
      piaw_pkg::COND_REQ_NOP: take = (rtype_q == piaw_pkg::REQ_NOP);
      piaw_pkg::COND_STOPPED: take = !stat_i.running;
      piaw_pkg::COND_KI_ZERO: take = stat_i.ki_zero;
      default:                take = 1'b0;
    endcase
  end

  assign req_ready_o  = (state_q == ST_IDLE);
  assign accept       = req_valid_i && req_ready_o;
  assign finish       = (state_q == ST_EXEC) && uw.last && (!res_valid_q || res_ready_i);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign ctrl_o.load  = accept;
  assign ctrl_o.op    = (state_q == ST_EXEC) ? uw.op : piaw_pkg::OP_NOP;
  assign ctrl_o.src_a = uw.src_a;
  assign ctrl_o.src_b = uw.src_b;
  assign ctrl_o.dst   = uw.dst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rtype_q     <= piaw_pkg::REQ_SAMPLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_valid_q && res_ready_i && !finish) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
            step_q  <= '0;
            rtype_q <= req_type_i;
          end
        end
        ST_EXEC: begin
          if (uw.last) begin
            if (finish) begin
              res_valid_q   <= 1'b1;
              res_q.drive   <= stat_i.drive;
              res_q.running <= stat_i.running;
              state_q       <= ST_IDLE;
            end
          end else begin
            step_q <= take ? uw.target : step_q + 1'b1;
          end
        end
      endcase
    end
  end

  `PIAW_ASSERT_NEXT(a_accept_starts_program, clk_i, rst_ni, accept, (state_q == ST_EXEC) && (step_q == '0), "accepted item does not start at step zero")
  `PIAW_ASSERT_IMPL(a_step_in_program, clk_i, rst_ni, state_q == ST_EXEC, step_q <= piaw_pkg::StepEnd, "step counter ran past the program")
  `PIAW_ASSERT_NEXT(a_finish_gives_result, clk_i, rst_ni, finish, res_valid_q && (state_q == ST_IDLE), "finished item left no result")
  `PIAW_ASSERT_IMPL(a_no_accept_while_busy, clk_i, rst_ni, state_q == ST_EXEC, !req_ready_o, "item accepted during execution")

endmodule

// File: tb/testbench.sv
// testbench for pi_controller_antiwindup_core: directed table, then random items
// checked against a cycle-free PI/anti-windup predictor; uses piaw_pkg, piaw_stream_if
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 32;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    piaw_pkg::req_e     req;
    piaw_pkg::data_t    meas;
    piaw_pkg::data_t    sp;
    piaw_pkg::cfg_idx_e idx;
    logic [31:0]        wdata;
    bit                 known;
    piaw_pkg::data_t    drive;
    logic               running;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  piaw_stream_if #(.payload_t(piaw_pkg::req_t)) req_ch ();
  piaw_stream_if #(.payload_t(piaw_pkg::res_t)) res_ch ();
  piaw_stream_if #(.payload_t(piaw_pkg::cfg_t)) cfg_ch ();

  pi_controller_antiwindup_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // predictor copy of registers and controller state
  piaw_pkg::gain_t g_kp, g_ki, g_kb, g_dz;
  piaw_pkg::data_t lim_lo, lim_hi, ofs_out, ofs_in;
  piaw_pkg::data_t acc_int, aw_corr, drive_q;
  logic            is_running;

  piaw_pkg::res_t drive_due_q[$];
  dir_row_t       dir_tab[$];
  int             fail_count;
  int             cycle_count;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout, %0d items still due", $time, drive_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic piaw_pkg::data_t clip32(longint v);
    if (v > longint'(piaw_pkg::DataMax)) return piaw_pkg::DataMax;
    if (v < longint'(piaw_pkg::DataMin)) return piaw_pkg::DataMin;
    return piaw_pkg::data_t'(v);
  endfunction

  function automatic piaw_pkg::data_t scale_mul(piaw_pkg::gain_t g, piaw_pkg::data_t x);
    longint gl, xl;
    gl = g;
    xl = x;
    return clip32((gl * xl) >>> piaw_pkg::FracBits);
  endfunction

  function automatic piaw_pkg::res_t predict_drive(piaw_pkg::req_t r);
    piaw_pkg::data_t meas_c, err, p_term, unc, drv;
    piaw_pkg::res_t  o;
    case (r.req_type)
      piaw_pkg::REQ_SAMPLE: begin
        unc = '0;
        if (is_running) begin
          meas_c = clip32(longint'(r.measurement) - longint'(ofs_in));
          err = clip32(longint'(r.setpoint) - longint'(meas_c));
          if (g_dz != 0 && longint'(err) < longint'(g_dz) &&
              longint'(err) > -longint'(g_dz))
            err = '0;
          p_term = scale_mul(g_kp, err);
          if (g_ki != 0)
            acc_int = clip32(longint'(acc_int) +
                             longint'(scale_mul(g_ki,
                                      clip32(longint'(err) + longint'(aw_corr)))));
          else
            acc_int = '0;
          unc = clip32(longint'(p_term) + longint'(acc_int));
        end
        unc = clip32(longint'(unc) + longint'(ofs_out));
        if (unc < lim_lo) drv = lim_lo;
        else if (unc > lim_hi) drv = lim_hi;
        else drv = unc;
        aw_corr = scale_mul(g_kb, clip32(longint'(drv) - longint'(unc)));
        drive_q = drv;
      end
      piaw_pkg::REQ_ON: begin
        is_running = 1'b1;
      end
      piaw_pkg::REQ_OFF: begin
        acc_int = '0;
        aw_corr = '0;
        drive_q = ofs_out;
        is_running = 1'b0;
      end
      default: begin
      end
    endcase
    o.drive = drive_q;
    o.running = is_running;
    return o;
  endfunction

  task automatic check_drive(piaw_pkg::res_t got);
    piaw_pkg::res_t want;
    if (drive_due_q.size() == 0) begin
      $display("%0t: unexpected item, got drive %0d running %0b", $time, got.drive,
               got.running);
      fail_count++;
    end else begin
      want = drive_due_q.pop_front();
      if (got.drive !== want.drive) begin
        $display("%0t: drive expected %0d, got %0d", $time, want.drive, got.drive);
        fail_count++;
      end
      if (got.running !== want.running) begin
        $display("%0t: running expected %0b, got %0b", $time, want.running, got.running);
        fail_count++;
      end
    end
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin : result_side
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) check_drive(res_ch.payload);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // lowers valid only while results are still due, then waits until none is due
  task automatic wait_outputs_settled();
    if (drive_due_q.size() != 0) begin
      req_ch.valid <= 1'b0;
      while (drive_due_q.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic send_item(piaw_pkg::req_t r, bit known, piaw_pkg::res_t known_res);
    piaw_pkg::res_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    o = predict_drive(r);
    drive_due_q.push_back(known ? known_res : o);
  endtask

  // leaves valid high; caller lowers it after the last write
  task automatic write_reg(piaw_pkg::cfg_idx_e idx, logic [31:0] val);
    piaw_pkg::cfg_t c;
    c.index = idx;
    c.wdata = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= c;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      piaw_pkg::CFG_KP:         g_kp = val[piaw_pkg::GainW-1:0];
      piaw_pkg::CFG_KI_TS:      g_ki = val[piaw_pkg::GainW-1:0];
      piaw_pkg::CFG_KB:         g_kb = val[piaw_pkg::GainW-1:0];
      piaw_pkg::CFG_DEADZONE:   g_dz = val[piaw_pkg::GainW-1:0];
      piaw_pkg::CFG_OUT_MIN:    lim_lo = piaw_pkg::data_t'(val);
      piaw_pkg::CFG_OUT_MAX:    lim_hi = piaw_pkg::data_t'(val);
      piaw_pkg::CFG_OUT_OFFSET: ofs_out = piaw_pkg::data_t'(val);
      piaw_pkg::CFG_IN_OFFSET:  ofs_in = piaw_pkg::data_t'(val);
      default: begin
      end
    endcase
  endtask

  task automatic load_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] kb,
                             logic [31:0] dz, piaw_pkg::data_t lo, piaw_pkg::data_t hi,
                             piaw_pkg::data_t oofs, piaw_pkg::data_t iofs);
    write_reg(piaw_pkg::CFG_KP, kp);
    write_reg(piaw_pkg::CFG_KI_TS, ki);
    write_reg(piaw_pkg::CFG_KB, kb);
    write_reg(piaw_pkg::CFG_DEADZONE, dz);
    write_reg(piaw_pkg::CFG_OUT_MIN, lo);
    write_reg(piaw_pkg::CFG_OUT_MAX, hi);
    write_reg(piaw_pkg::CFG_OUT_OFFSET, oofs);
    write_reg(piaw_pkg::CFG_IN_OFFSET, iofs);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic piaw_pkg::data_t pick_value(int span);
    case ($urandom_range(9))
      0: return piaw_pkg::DataMin;
      1: return piaw_pkg::DataMax;
      2, 3: return piaw_pkg::data_t'($urandom);
      default: return piaw_pkg::data_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(32'h3_0000);
      4: return $urandom_range(32'h2000);
      default: return $urandom;
    endcase
  endfunction

  task automatic config_for_segment(int seg);
    piaw_pkg::data_t lo, hi, tmp;
    logic [31:0] dz;
    if (seg == 1) begin
      load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  piaw_pkg::DataMin, piaw_pkg::DataMax, piaw_pkg::DataMax,
                  piaw_pkg::DataMin);
    end else if (seg == 5) begin
      load_config(32'd0, 32'd0, 32'd0, 32'd0, piaw_pkg::DataMax, piaw_pkg::DataMin,
                  piaw_pkg::DataMin, piaw_pkg::DataMax);
    end else begin
      lo = -piaw_pkg::data_t'($urandom_range(32'h30_0000));
      hi = piaw_pkg::data_t'($urandom_range(32'h30_0000));
      case ($urandom_range(5))
        0: begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
        1: begin
          lo = piaw_pkg::DataMin;
          hi = piaw_pkg::DataMax;
        end
        default: begin
        end
      endcase
      case ($urandom_range(3))
        0: dz = $urandom;
        1: dz = $urandom_range(32'h2_0000);
        default: dz = 32'd0;
      endcase
      load_config(pick_gain(), pick_gain(), pick_gain(), dz, lo, hi,
                  pick_value(32'h8_0000), pick_value(32'h8_0000));
    end
  endtask

  function automatic piaw_pkg::req_t random_item();
    piaw_pkg::req_t r;
    int             roll;
    roll = $urandom_range(99);
    r.setpoint = pick_value(32'h40_0000);
    if ($urandom_range(7) == 0)
      r.measurement = pick_value(32'h40_0000);
    else
      r.measurement = r.setpoint + ofs_in +
                      piaw_pkg::data_t'(int'($urandom_range(32'h8_0000)) - 32'h4_0000);
    if (!is_running && $urandom_range(3) != 0) r.req_type = piaw_pkg::REQ_ON;
    else if (roll < 5) r.req_type = piaw_pkg::REQ_NOP;
    else if (roll < 11) r.req_type = piaw_pkg::REQ_ON;
    else if (roll < 16) r.req_type = piaw_pkg::REQ_OFF;
    else r.req_type = piaw_pkg::REQ_SAMPLE;
    return r;
  endfunction

  function automatic dir_row_t item_row(piaw_pkg::req_e req, piaw_pkg::data_t meas,
                                        piaw_pkg::data_t sp);
    dir_row_t d;
    d.kind = ROW_ITEM;
    d.req = req;
    d.meas = meas;
    d.sp = sp;
    d.idx = piaw_pkg::CFG_KP;
    d.wdata = '0;
    d.known = 1'b0;
    d.drive = '0;
    d.running = 1'b0;
    return d;
  endfunction

  function automatic dir_row_t known_row(piaw_pkg::req_e req, piaw_pkg::data_t meas,
                                         piaw_pkg::data_t sp, piaw_pkg::data_t drive,
                                         logic running);
    dir_row_t d;
    d = item_row(req, meas, sp);
    d.known = 1'b1;
    d.drive = drive;
    d.running = running;
    return d;
  endfunction

  function automatic dir_row_t reg_row(piaw_pkg::cfg_idx_e idx, logic [31:0] val);
    dir_row_t d;
    d = item_row(piaw_pkg::REQ_NOP, '0, '0);
    d.kind = ROW_REG;
    d.idx = idx;
    d.wdata = val;
    return d;
  endfunction

  initial begin : stimulus
    piaw_pkg::req_t r;
    piaw_pkg::res_t k;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    g_kp = '0;
    g_ki = '0;
    g_kb = '0;
    g_dz = '0;
    lim_lo = piaw_pkg::DataMin;
    lim_hi = piaw_pkg::DataMax;
    ofs_out = '0;
    ofs_in = '0;
    acc_int = '0;
    aw_corr = '0;
    drive_q = '0;
    is_running = 1'b0;

    // reset register values and stopped state
    dir_tab.push_back(known_row(piaw_pkg::REQ_SAMPLE, 0, 0, 0, 1'b0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_NOP, 0, 0, 0, 1'b0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_ON, 0, 0, 0, 1'b1));
    dir_tab.push_back(known_row(piaw_pkg::REQ_SAMPLE, piaw_pkg::DataMax, piaw_pkg::DataMin,
                                0, 1'b1));
    dir_tab.push_back(known_row(piaw_pkg::REQ_OFF, 0, 0, 0, 1'b0));
    // full kp and ki_ts, narrow clamp: saturation everywhere
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KP, 32'h7FFF_FFFF));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KI_TS, 32'h7FFF_FFFF));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KB, 32'h0001_0000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_DEADZONE, 32'd0));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MIN, -32'sd655360));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MAX, 32'sd655360));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_OFFSET, 32'h0001_0000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_IN_OFFSET, 32'd0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_SAMPLE, 32'h5_0000, 32'h3_0000, 32'h1_0000,
                                1'b0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_ON, 0, 0, 32'h1_0000, 1'b1));
    dir_tab.push_back(known_row(piaw_pkg::REQ_SAMPLE, piaw_pkg::DataMax, piaw_pkg::DataMin,
                                -32'sd655360, 1'b1));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, piaw_pkg::DataMin, piaw_pkg::DataMax));
    dir_tab.push_back(known_row(piaw_pkg::REQ_OFF, 0, 0, 32'h1_0000, 1'b0));
    // deadzone edges and an inverted clamp
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KP, 32'h0001_0000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KI_TS, 32'h0000_8000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KB, 32'h0000_8000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_DEADZONE, 32'h0000_8000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MIN, 32'h0005_0000));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MAX, -32'sd327680));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_OFFSET, 32'd0));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_IN_OFFSET, 32'h0002_0000));
    dir_tab.push_back(known_row(piaw_pkg::REQ_ON, 0, 0, 32'h1_0000, 1'b1));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, 32'h2_4000, 0));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, 32'h2_0000, 32'h8000));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, 32'h2_8000, 0));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, 0, 32'h7FFF_0000));
    // integrator cleared by zero ki, widest deadzone, extreme offsets
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KI_TS, 32'd0));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_KB, 32'h7FFF_FFFF));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_DEADZONE, 32'h7FFF_FFFF));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MIN, piaw_pkg::DataMin));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_MAX, piaw_pkg::DataMax));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_OUT_OFFSET, piaw_pkg::DataMax));
    dir_tab.push_back(reg_row(piaw_pkg::CFG_IN_OFFSET, piaw_pkg::DataMin));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, piaw_pkg::DataMax, piaw_pkg::DataMax));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, -1, 0));
    dir_tab.push_back(item_row(piaw_pkg::REQ_NOP, 0, 0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_OFF, 0, 0, piaw_pkg::DataMax, 1'b0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_SAMPLE, 32'h1234, 32'h5678, piaw_pkg::DataMax,
                                1'b0));
    dir_tab.push_back(known_row(piaw_pkg::REQ_ON, 0, 0, piaw_pkg::DataMax, 1'b1));
    dir_tab.push_back(item_row(piaw_pkg::REQ_SAMPLE, 0, 32'h1_0000));
    dir_tab.push_back(known_row(piaw_pkg::REQ_OFF, 0, 0, piaw_pkg::DataMax, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_outputs_settled();
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
        if (i == dir_tab.size() - 1 || dir_tab[i + 1].kind != ROW_REG) cfg_ch.valid <= 1'b0;
      end else begin
        r.req_type = dir_tab[i].req;
        r.measurement = dir_tab[i].meas;
        r.setpoint = dir_tab[i].sp;
        k.drive = dir_tab[i].drive;
        k.running = dir_tab[i].running;
        send_item(r, dir_tab[i].known, k);
      end
    end

    for (int seg = 0; seg < 8; seg++) begin
      wait_outputs_settled();
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      config_for_segment(seg);
      for (int n = 0; n < 64; n++) begin
        if (seg == 0 && n == 20) hold_req = ~hold_req;
        if ((seg == 0 && n == 40) || $urandom_range(49) == 0) wait_outputs_settled();
        send_item(random_item(), 1'b0, '0);
      end
    end

    wait_outputs_settled();
    recv_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
